// ===== rtl/hidrd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the HID report descriptor parser: result kinds, item tag codes,
// the global state record and small decode helpers.
// It depends on nothing else.
package hidrd_pkg;

    typedef enum logic [2:0] {
        KIND_INPUT       = 3'd0,
        KIND_OUTPUT      = 3'd1,
        KIND_FEATURE     = 3'd2,
        KIND_APP_CLOSED  = 3'd3,
        KIND_STACK_ERROR = 3'd4
    } kind_t;

    localparam logic [7:0] TAG_MASK  = 8'hFC;
    localparam logic [7:0] TYPE_MASK = 8'h0C;
    localparam logic [7:0] SIZE_MASK = 8'h03;
    localparam logic [7:0] COLL_APPLICATION = 8'h01;

    localparam logic [7:0] TAG_INPUT          = 8'h80;
    localparam logic [7:0] TAG_OUTPUT         = 8'h90;
    localparam logic [7:0] TAG_FEATURE        = 8'hB0;
    localparam logic [7:0] TAG_COLLECTION     = 8'hA0;
    localparam logic [7:0] TAG_END_COLLECTION = 8'hC0;
    localparam logic [7:0] TAG_PAGE           = 8'h04;
    localparam logic [7:0] TAG_LMIN           = 8'h14;
    localparam logic [7:0] TAG_LMAX           = 8'h24;
    localparam logic [7:0] TAG_REPORT_SIZE    = 8'h74;
    localparam logic [7:0] TAG_RID            = 8'h84;
    localparam logic [7:0] TAG_REPORT_COUNT   = 8'h94;
    localparam logic [7:0] TAG_PUSH           = 8'hA4;
    localparam logic [7:0] TAG_POP            = 8'hB4;
    localparam logic [7:0] TAG_USAGE          = 8'h08;
    localparam logic [7:0] TAG_USAGE_MIN      = 8'h18;
    localparam logic [7:0] TAG_USAGE_MAX      = 8'h28;

    typedef struct packed {
        logic [15:0] page;
        logic [7:0]  rsize;
        logic [7:0]  rcount;
        logic [7:0]  rid;
        logic [31:0] lmin;
        logic [31:0] lmax;
    } globals_t;

    // Number of data bytes that follow a prefix: codes 0, 1, 2, 3 give 0, 1, 2, 4.
    function automatic logic [2:0] size_bytes(input logic [7:0] prefix);
        logic [1:0] code;
        code = prefix[1:0] & SIZE_MASK[1:0];
        return (code == 2'd3) ? 3'd4 : {1'b0, code};
    endfunction

    function automatic logic [31:0] sign_ext(input logic [31:0] v, input logic [1:0] code);
        logic [31:0] r;
        case (code)
            2'd0:    r = 32'd0;
            2'd1:    r = {{24{v[7]}}, v[7:0]};
            2'd2:    r = {{16{v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/hid_report_descriptor_parser_top.sv =====
`timescale 1ns / 1ps
// A byte accepted into the input register has its result, if any, registered in the result
// register and presented on the master side until taken (input register, then result).
// Throughput: one descriptor byte per cycle, stalled while a pending result waits on m_tready.
// Reset: aresetn is synchronous and active low; it empties both stages and clears all
// parse state. A byte with tlast high clears the parse state again after it is handled.
// Depends on hidrd_pkg for kinds, tag codes and decode helpers.
module hid_report_descriptor_parser_top #(
    parameter int PUSH_DEPTH       = 4,
    parameter int COLLECTION_DEPTH = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // rid[7:0], bit_offset[23:8], bit_length[39:24], page[55:40],
    // usage_first[71:56], usage_count[87:72], lmin[119:88],
    // lmax[151:120], field_size[159:152], field_count[167:160]
    output logic [167:0] m_tdata,
    output logic [2:0]   m_tuser    // kind[2:0]
);

    localparam int PCW = $clog2(PUSH_DEPTH + 1);
    localparam int PIW = (PUSH_DEPTH > 1) ? $clog2(PUSH_DEPTH) : 1;
    localparam int CCW = $clog2(COLLECTION_DEPTH + 1);
    localparam int CIW = (COLLECTION_DEPTH > 1) ? $clog2(COLLECTION_DEPTH) : 1;

    logic                 in_valid_reg;
    logic [7:0]           in_data_reg;
    logic                 in_last_reg;
    logic                 advance;

    logic [2:0]           bytes_left_reg, bytes_left_next;
    logic [7:0]           prefix_reg, prefix_next;
    logic [31:0]          accum_reg, accum_next;
    hidrd_pkg::globals_t  glob_reg, glob_next;
    logic [PCW-1:0]       push_ptr_reg, push_ptr_next;
    logic [CCW-1:0]       coll_ptr_reg, coll_ptr_next;
    logic                 app_valid_reg, app_valid_next;
    logic [15:0]          app_page_reg, app_page_next;
    logic [15:0]          app_id_reg, app_id_next;
    logic [15:0]          loc_first_reg, loc_first_next;
    logic [15:0]          loc_last_reg, loc_last_next;
    logic [15:0]          loc_count_reg, loc_count_next;
    logic [15:0]          off_reg [3];
    logic [15:0]          off_next [3];

    hidrd_pkg::globals_t  push_stack [PUSH_DEPTH];
    logic                 coll_flags [COLLECTION_DEPTH];

    logic                 push_we;
    logic                 flag_we;
    logic                 flag_wdata;
    logic [PCW-1:0]       push_ptr_dec;
    logic [CCW-1:0]       coll_ptr_dec;

    logic                 m_valid_reg;
    hidrd_pkg::kind_t     m_kind_reg;
    logic [167:0]         m_data_reg;

    logic                 res_valid;
    hidrd_pkg::kind_t     res_kind;
    logic [15:0]          res_offset, res_length, res_page, res_ufirst, res_ucount;
    logic [31:0]          res_lmin, res_lmax;
    logic [7:0]           res_fsize, res_fcount;

    logic                 exec;
    logic [7:0]           item_p;
    logic [31:0]          item_v;
    logic [1:0]           pos;
    logic [7:0]           tag;
    logic [1:0]           field_idx;
    logic [16:0]          off_sum;
    logic [15:0]          usage_top;
    logic [16:0]          usage_cnt;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

    assign push_ptr_dec = push_ptr_reg - PCW'(1);
    assign coll_ptr_dec = coll_ptr_reg - CCW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_comb begin
        bytes_left_next = bytes_left_reg;
        prefix_next     = prefix_reg;
        accum_next      = accum_reg;
        glob_next       = glob_reg;
        push_ptr_next   = push_ptr_reg;
        coll_ptr_next   = coll_ptr_reg;
        app_valid_next  = app_valid_reg;
        app_page_next   = app_page_reg;
        app_id_next     = app_id_reg;
        loc_first_next  = loc_first_reg;
        loc_last_next   = loc_last_reg;
        loc_count_next  = loc_count_reg;
        off_next        = off_reg;
        push_we         = 1'b0;
        flag_we         = 1'b0;
        flag_wdata      = 1'b0;
        res_valid       = 1'b0;
        res_kind        = hidrd_pkg::KIND_STACK_ERROR;
        res_offset      = 16'd0;
        res_length      = 16'd0;
        res_page        = 16'd0;
        res_ufirst      = 16'd0;
        res_ucount      = 16'd0;
        res_lmin        = 32'd0;
        res_lmax        = 32'd0;
        res_fsize       = 8'd0;
        res_fcount      = 8'd0;
        field_idx       = 2'd0;
        off_sum         = 17'd0;
        usage_top       = 16'd0;
        usage_cnt       = 17'd0;
        pos             = 2'd0;

        if (bytes_left_reg == 3'd0) begin
            prefix_next     = in_data_reg;
            accum_next      = 32'd0;
            bytes_left_next = hidrd_pkg::size_bytes(in_data_reg);
            exec            = (hidrd_pkg::size_bytes(in_data_reg) == 3'd0);
            item_p          = in_data_reg;
            item_v          = 32'd0;
        end else begin
            pos             = 2'(hidrd_pkg::size_bytes(prefix_reg) - bytes_left_reg);
            accum_next      = accum_reg | ({24'd0, in_data_reg} << {pos, 3'b000});
            bytes_left_next = bytes_left_reg - 3'd1;
            exec            = (bytes_left_reg == 3'd1);
            item_p          = prefix_reg;
            item_v          = accum_next;
        end
        tag = item_p & hidrd_pkg::TAG_MASK;

        if (exec) begin
            unique case (tag)
                hidrd_pkg::TAG_INPUT, hidrd_pkg::TAG_OUTPUT, hidrd_pkg::TAG_FEATURE: begin
                    if (app_valid_reg) begin
                        if (tag == hidrd_pkg::TAG_INPUT) begin
                            res_kind  = hidrd_pkg::KIND_INPUT;
                            field_idx = 2'd0;
                        end else if (tag == hidrd_pkg::TAG_OUTPUT) begin
                            res_kind  = hidrd_pkg::KIND_OUTPUT;
                            field_idx = 2'd1;
                        end else begin
                            res_kind  = hidrd_pkg::KIND_FEATURE;
                            field_idx = 2'd2;
                        end
                        res_valid  = 1'b1;
                        res_length = 16'(glob_reg.rsize) * 16'(glob_reg.rcount);
                        res_offset = off_reg[field_idx];
                        off_sum    = {1'b0, res_offset} + {1'b0, res_length};
                        off_next[field_idx] = off_sum[16] ? 16'hFFFF : off_sum[15:0];
                        res_page   = glob_reg.page;
                        res_ufirst = (loc_count_reg != 16'd0) ? loc_first_reg : 16'd0;
                        res_ucount = loc_count_reg;
                        res_lmin   = glob_reg.lmin;
                        res_lmax   = glob_reg.lmax;
                        res_fsize  = glob_reg.rsize;
                        res_fcount = glob_reg.rcount;
                    end
                end
                hidrd_pkg::TAG_COLLECTION: begin
                    if (coll_ptr_reg == CCW'(COLLECTION_DEPTH)) begin
                        res_valid = 1'b1;
                        res_kind  = hidrd_pkg::KIND_STACK_ERROR;
                    end else begin
                        flag_we       = 1'b1;
                        flag_wdata    = (item_v[7:0] == hidrd_pkg::COLL_APPLICATION);
                        coll_ptr_next = coll_ptr_reg + CCW'(1);
                        if (flag_wdata) begin
                            app_valid_next = 1'b1;
                            app_page_next  = glob_reg.page;
                            app_id_next    = (loc_count_reg != 16'd0) ? loc_last_reg : 16'd0;
                            off_next[0]    = 16'd0;
                            off_next[1]    = 16'd0;
                            off_next[2]    = 16'd0;
                        end
                    end
                end
                hidrd_pkg::TAG_END_COLLECTION: begin
                    if (coll_ptr_reg == CCW'(0)) begin
                        res_valid = 1'b1;
                        res_kind  = hidrd_pkg::KIND_STACK_ERROR;
                    end else begin
                        coll_ptr_next = coll_ptr_dec;
                        if (coll_flags[coll_ptr_dec[CIW-1:0]]) begin
                            res_valid      = 1'b1;
                            res_kind       = hidrd_pkg::KIND_APP_CLOSED;
                            res_page       = app_page_reg;
                            res_ufirst     = app_id_reg;
                            app_valid_next = 1'b0;
                        end
                    end
                end
                hidrd_pkg::TAG_PAGE:         glob_next.page   = item_v[15:0];
                hidrd_pkg::TAG_LMIN:
                    glob_next.lmin = hidrd_pkg::sign_ext(item_v, item_p[1:0]);
                hidrd_pkg::TAG_LMAX:
                    glob_next.lmax = hidrd_pkg::sign_ext(item_v, item_p[1:0]);
                hidrd_pkg::TAG_REPORT_SIZE:  glob_next.rsize  = item_v[7:0];
                hidrd_pkg::TAG_RID:          glob_next.rid    = item_v[7:0];
                hidrd_pkg::TAG_REPORT_COUNT: glob_next.rcount = item_v[7:0];
                hidrd_pkg::TAG_PUSH: begin
                    if (push_ptr_reg == PCW'(PUSH_DEPTH)) begin
                        res_valid = 1'b1;
                        res_kind  = hidrd_pkg::KIND_STACK_ERROR;
                    end else begin
                        push_we       = 1'b1;
                        push_ptr_next = push_ptr_reg + PCW'(1);
                    end
                end
                hidrd_pkg::TAG_POP: begin
                    if (push_ptr_reg == PCW'(0)) begin
                        res_valid = 1'b1;
                        res_kind  = hidrd_pkg::KIND_STACK_ERROR;
                    end else begin
                        push_ptr_next = push_ptr_dec;
                        glob_next     = push_stack[push_ptr_dec[PIW-1:0]];
                    end
                end
                hidrd_pkg::TAG_USAGE, hidrd_pkg::TAG_USAGE_MIN: begin
                    if (loc_count_reg == 16'd0) begin
                        loc_first_next = item_v[15:0];
                    end
                    loc_last_next = item_v[15:0];
                    if (loc_count_reg != 16'hFFFF) begin
                        loc_count_next = loc_count_reg + 16'd1;
                    end
                end
                hidrd_pkg::TAG_USAGE_MAX: begin
                    usage_top = (item_v[31:16] != 16'd0) ? 16'hFFFF : item_v[15:0];
                    usage_cnt = {1'b0, loc_count_reg} + {1'b0, usage_top - loc_last_reg};
                    if (loc_count_reg != 16'd0 && usage_top > loc_last_reg) begin
                        loc_count_next = usage_cnt[16] ? 16'hFFFF : usage_cnt[15:0];
                        loc_last_next  = usage_top;
                    end
                end
                default: begin
                end
            endcase
            if ((item_p & hidrd_pkg::TYPE_MASK) == 8'd0) begin
                loc_first_next = 16'd0;
                loc_last_next  = 16'd0;
                loc_count_next = 16'd0;
            end
        end

        if (in_last_reg) begin
            bytes_left_next = 3'd0;
            prefix_next     = 8'd0;
            accum_next      = 32'd0;
            glob_next       = '0;
            push_ptr_next   = PCW'(0);
            coll_ptr_next   = CCW'(0);
            app_valid_next  = 1'b0;
            app_page_next   = 16'd0;
            app_id_next     = 16'd0;
            loc_first_next  = 16'd0;
            loc_last_next   = 16'd0;
            loc_count_next  = 16'd0;
            off_next[0]     = 16'd0;
            off_next[1]     = 16'd0;
            off_next[2]     = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= 3'd0;
            prefix_reg     <= 8'd0;
            accum_reg      <= 32'd0;
            glob_reg       <= '0;
            push_ptr_reg   <= PCW'(0);
            coll_ptr_reg   <= CCW'(0);
            app_valid_reg  <= 1'b0;
            app_page_reg   <= 16'd0;
            app_id_reg     <= 16'd0;
            loc_first_reg  <= 16'd0;
            loc_last_reg   <= 16'd0;
            loc_count_reg  <= 16'd0;
            off_reg[0]     <= 16'd0;
            off_reg[1]     <= 16'd0;
            off_reg[2]     <= 16'd0;
        end else if (advance) begin
            bytes_left_reg <= bytes_left_next;
            prefix_reg     <= prefix_next;
            accum_reg      <= accum_next;
            glob_reg       <= glob_next;
            push_ptr_reg   <= push_ptr_next;
            coll_ptr_reg   <= coll_ptr_next;
            app_valid_reg  <= app_valid_next;
            app_page_reg   <= app_page_next;
            app_id_reg     <= app_id_next;
            loc_first_reg  <= loc_first_next;
            loc_last_reg   <= loc_last_next;
            loc_count_reg  <= loc_count_next;
            off_reg        <= off_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && push_we) begin
            push_stack[push_ptr_reg[PIW-1:0]] <= glob_reg;
        end
        if (advance && flag_we) begin
            coll_flags[coll_ptr_reg[CIW-1:0]] <= flag_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && res_valid) begin
            m_kind_reg <= res_kind;
            m_data_reg <= {res_fcount, res_fsize, res_lmax, res_lmin, res_ucount,
                           res_ufirst, res_page, res_length, res_offset, glob_reg.rid};
        end
    end

    // A transaction carrying the final byte leaves the parser with no open item or nesting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=>
            (bytes_left_reg == 3'd0 && push_ptr_reg == PCW'(0) && coll_ptr_reg == CCW'(0)
             && !app_valid_reg))
        else $error("parse state not cleared after the final descriptor byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push_ptr_reg <= PCW'(PUSH_DEPTH)) && (coll_ptr_reg <= CCW'(COLLECTION_DEPTH)))
        else $error("stack pointer beyond its depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("pending result overwritten while stalled");

endmodule
